[design/odo_pkg.sv]
// Shared constants, types and tables for the wheel odometry block.
package odo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int POLY_TERMS   = 5;

    // Serial multiplier operand and product widths
    localparam int MA_W = 65;
    localparam int MB_W = 34;
    localparam int MP_W = MA_W + MB_W;

    // Serial divider dividend and divisor widths
    localparam int DN_W = MP_W;
    localparam int DD_W = 33;

    // CORDIC datapath width
    localparam int CW = 34;

    localparam logic [63:0]        TURN_PER_RAD = 64'h28BE_60DB_9391_054A;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032875;

    typedef enum logic [2:0] {
        REG_LEFT_OFFSET   = 3'd0,
        REG_RIGHT_OFFSET  = 3'd1,
        REG_START_X       = 3'd2,
        REG_START_Y       = 3'd3,
        REG_START_HEADING = 3'd4
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SETUP,
        ST_HALF_MUL,
        ST_HALF_DIV,
        ST_X_DIV,
        ST_X2_MUL,
        ST_P_MUL,
        ST_P_DIV,
        ST_SC_COR,
        ST_SC_MUL,
        ST_SC_DIV,
        ST_N_MUL_R,
        ST_N_MUL_L,
        ST_N_DIV,
        ST_S_MUL_Q,
        ST_S_MUL_R,
        ST_S_DIV,
        ST_ROT,
        ST_X_MUL,
        ST_Y_MUL,
        ST_DONE
    } st_t;

    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            5'd30:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Divisors of the nested sinc series, innermost first
    function automatic logic [6:0] poly_div(input logic [2:0] k);
        logic [6:0] v;
        case (k)
            3'd0:    v = 7'd110;
            3'd1:    v = 7'd72;
            3'd2:    v = 7'd42;
            3'd3:    v = 7'd20;
            default: v = 7'd6;
        endcase
        return v;
    endfunction

endpackage

[design/odo_mul.sv]
// Bit-serial signed multiplier: one bit of the second operand per cycle.
module odo_mul
    import odo_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [MA_W-1:0] a,
    input  logic signed [MB_W-1:0] b,
    output logic                   done,
    output logic signed [MP_W-1:0] p
);

    localparam int CNT_W = $clog2(MB_W);

    logic             busy_reg;
    logic             fin_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [MA_W-1:0]  ma_reg;
    logic [MP_W-1:0]  acc_reg;

    logic [MA_W-1:0]  ma_in;
    logic [MB_W-1:0]  mb_in;
    logic [MA_W:0]    sum;
    logic [MP_W-1:0]  acc_next;

    assign ma_in = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
    assign mb_in = b[MB_W-1] ? MB_W'(-b) : MB_W'(b);
    assign sum   = {1'b0, acc_reg[MP_W-1:MB_W]} + {1'b0, ma_reg};

    always_comb
    begin
        if (acc_reg[0])
        begin
            acc_next = {sum, acc_reg[MB_W-1:1]};
        end
        else
        begin
            acc_next = {1'b0, acc_reg[MP_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MB_W - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= {{MA_W{1'b0}}, mb_in};
            ma_reg  <= ma_in;
            neg_reg <= a[MA_W-1] ^ b[MB_W-1];
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = fin_reg;
    assign p    = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

endmodule

[design/odo_div.sv]
// Bit-serial floor divider: signed dividend, positive divisor, one bit per cycle.
module odo_div
    import odo_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [DN_W-1:0] num,
    input  logic [DD_W-1:0]        den,
    output logic                   done,
    output logic [DN_W-1:0]        quo,
    output logic [DD_W-1:0]        rem
);

    localparam int CNT_W = $clog2(DN_W);

    logic             busy_reg;
    logic             fin_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DD_W-1:0]  den_reg;
    logic [DN_W-1:0]  qr_reg;
    logic [DD_W-1:0]  rem_reg;

    logic [DD_W:0]    trial;
    logic             fits;
    logic [DD_W-1:0]  rem_next;

    assign trial    = {rem_reg, qr_reg[DN_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? DD_W'(trial - {1'b0, den_reg}) : trial[DD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // A negative dividend is divided in ones' complement and the quotient inverted
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[DN_W-1];
            qr_reg  <= num[DN_W-1] ? ~num : num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            qr_reg  <= {qr_reg[DN_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done = fin_reg;
    assign quo  = neg_reg ? ~qr_reg : qr_reg;
    assign rem  = neg_reg ? DD_W'(den_reg - 1'b1 - rem_reg) : rem_reg;

endmodule

[design/odo_cordic.sv]
// Iterative rotation-mode CORDIC giving Q30 cosine and sine of a binary angle.
module odo_cordic
    import odo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          angle,
    output logic                 done,
    output logic signed [CW-1:0] cos_out,
    output logic signed [CW-1:0] sin_out
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);

    logic                 busy_reg;
    logic                 fin_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [1:0]           quad_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;

    logic [31:0]          ang_rnd;
    logic [1:0]           quad;
    logic [31:0]          z_red;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;

    assign ang_rnd = angle + 32'h2000_0000;
    assign quad    = ang_rnd[31:30];
    assign z_red   = angle - {quad, 30'd0};
    assign dx      = y_reg >>> cnt_reg;
    assign dy      = x_reg >>> cnt_reg;
    assign at      = $signed({{(CW-30){1'b0}}, atan_entry(5'(cnt_reg))});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quad_reg <= quad;
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({{(CW-32){z_red[31]}}, z_red});
        end
        else if (busy_reg)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    // Fold the reduced result back into its quadrant
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_out = x_reg;
                sin_out = y_reg;
            end
            2'd1:
            begin
                cos_out = -y_reg;
                sin_out = x_reg;
            end
            2'd2:
            begin
                cos_out = -x_reg;
                sin_out = -y_reg;
            end
            default:
            begin
                cos_out = y_reg;
                sin_out = -x_reg;
            end
        endcase
    end

    assign done = fin_reg;

endmodule

[design/differential_drive_odometry_top.sv]
// Two-wheel arc odometry: sequencer over shared serial multiplier, divider and CORDIC.
//
// Input items arrive on s_tvalid/s_tready: s_tuser is the action (0 update pose
// from the wheel readings, 1 restart at the start pose), s_tdata carries the
// absolute left and right wheel distances. Each item yields one result item
// on m_tvalid/m_tready holding the pose after that item.
// Offsets and the start pose are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high. Write them only while the block is idle.
// One item is worked on at a time; s_tready is high only when the sequencer
// is idle. A straight move takes one CORDIC pass and two multiplies. An arc
// runs each division in the bit-serial divider and each product in the
// bit-serial multiplier, with nine divisions and thirteen products on the
// small-angle path.
// The result sits in an output register, so the next item is accepted while it
// waits; the sequencer only holds at its last step when that register is full
// and the receiver stalls. Reset clears the pose and previous readings to zero
// and loads both offsets with 2785.
module differential_drive_odometry_top
    import odo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // left_distance, right_distance
    input  logic [0:0]  s_tuser,    // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,    // pos_x, pos_y, heading
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    st_t state_reg, state_next;
    logic issued_reg;

    logic [15:0] lo_reg, ro_reg;
    logic [31:0] sx_reg, sy_reg, sh_reg;
    logic [31:0] prev_l_reg, prev_r_reg;
    logic [31:0] tx_reg, ty_reg, th_reg;
    logic [2:0]  k_reg;
    logic        mv_reg;
    logic [95:0] out_reg;

    logic [31:0]          dl_reg, dr_reg;
    logic [32:0]          d_reg;
    logic [16:0]          sum_reg;
    logic [63:0]          half_reg;
    logic [31:0]          x_reg;
    logic [30:0]          x2_reg;
    logic [30:0]          t_reg;
    logic [31:0]          sinc_reg;
    logic [49:0]          n_reg;
    logic [32:0]          nq_reg;
    logic [16:0]          nr_reg;
    logic [65:0]          acc_reg;
    logic [33:0]          step_reg;
    logic signed [CW-1:0] c_reg, s_reg;
    logic [MP_W-1:0]      prod_reg;

    logic                   mul_start, mul_done;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;
    logic                   div_start, div_done;
    logic signed [DN_W-1:0] div_num;
    logic [DD_W-1:0]        div_den;
    logic [DN_W-1:0]        div_quo;
    logic [DD_W-1:0]        div_rem;
    logic                   cor_start, cor_done;
    logic [31:0]            cor_ang;
    logic signed [CW-1:0]   cor_cos, cor_sin;

    logic        accept, out_load;
    logic        mul_op, div_op, cor_op;
    logic [32:0] d_w;
    logic [16:0] sum_w;
    logic [17:0] s2;
    logic [32:0] d_abs;
    logic        d_small;
    logic [49:0] n_sum;
    logic [30:0] t_new;
    logic [65:0] step_sum;
    logic [61:0] pos_sum;
    logic [63:0] dth_sum;

    assign accept    = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!mv_reg || m_tready);
    assign cfg_ready = 1'b1;

    assign mul_op = state_reg inside {ST_HALF_MUL, ST_X2_MUL, ST_P_MUL, ST_SC_MUL,
                                      ST_N_MUL_R, ST_N_MUL_L, ST_S_MUL_Q, ST_S_MUL_R,
                                      ST_X_MUL, ST_Y_MUL};
    assign div_op = state_reg inside {ST_HALF_DIV, ST_X_DIV, ST_P_DIV, ST_SC_DIV,
                                      ST_N_DIV, ST_S_DIV};
    assign cor_op = state_reg inside {ST_SC_COR, ST_ROT};

    assign d_w      = {dr_reg[31], dr_reg} - {dl_reg[31], dl_reg};
    assign sum_w    = {1'b0, lo_reg} + {1'b0, ro_reg};
    assign s2       = {sum_reg, 1'b0};
    assign d_abs    = d_reg[32] ? 33'(-d_reg) : d_reg;
    assign d_small  = d_abs <= {15'd0, s2};
    assign n_sum    = n_reg + prod_reg[49:0];
    assign t_new    = 31'h4000_0000 - div_quo[30:0];
    assign step_sum = acc_reg + {{17{div_quo[48]}}, div_quo[48:0]} + 66'h2000_0000;
    assign pos_sum  = mul_p[61:0] + 62'h2000_0000;
    assign dth_sum  = {half_reg[62:0], 1'b0} + 64'h8000_0000;

    odo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    odo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    odo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_ang),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    state_next = s_tuser[0] ? ST_DONE : ST_SETUP;
                end
            ST_SETUP:
                state_next = (sum_w == 17'd0 || d_w == 33'd0) ? ST_ROT : ST_HALF_MUL;
            ST_HALF_MUL:
                if (mul_done) state_next = ST_HALF_DIV;
            ST_HALF_DIV:
                if (div_done) state_next = d_small ? ST_X_DIV : ST_SC_COR;
            ST_X_DIV:
                if (div_done) state_next = ST_X2_MUL;
            ST_X2_MUL:
                if (mul_done) state_next = ST_P_MUL;
            ST_P_MUL:
                if (mul_done) state_next = ST_P_DIV;
            ST_P_DIV:
                if (div_done)
                begin
                    state_next = (k_reg == 3'(POLY_TERMS - 1)) ? ST_N_MUL_R : ST_P_MUL;
                end
            ST_SC_COR:
                if (cor_done) state_next = ST_SC_MUL;
            ST_SC_MUL:
                if (mul_done) state_next = ST_SC_DIV;
            ST_SC_DIV:
                if (div_done) state_next = ST_N_MUL_R;
            ST_N_MUL_R:
                if (mul_done) state_next = ST_N_MUL_L;
            ST_N_MUL_L:
                if (mul_done) state_next = ST_N_DIV;
            ST_N_DIV:
                if (div_done) state_next = ST_S_MUL_Q;
            ST_S_MUL_Q:
                if (mul_done) state_next = ST_S_MUL_R;
            ST_S_MUL_R:
                if (mul_done) state_next = ST_S_DIV;
            ST_S_DIV:
                if (div_done) state_next = ST_ROT;
            ST_ROT:
                if (cor_done) state_next = ST_X_MUL;
            ST_X_MUL:
                if (mul_done) state_next = ST_Y_MUL;
            ST_Y_MUL:
                if (mul_done) state_next = ST_DONE;
            ST_DONE:
                if (out_load) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Unit starts and operand selection
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        mul_start = mul_op && !issued_reg;
        div_start = div_op && !issued_reg;
        cor_start = cor_op && !issued_reg;
        mul_a     = '0;
        mul_b     = '0;
        div_num   = '0;
        div_den   = '0;
        cor_ang   = '0;
        case (state_reg)
            ST_HALF_MUL:
            begin
                mul_a = $signed({1'b0, TURN_PER_RAD});
                mul_b = $signed({d_reg[32], d_reg});
            end
            ST_HALF_DIV:
            begin
                div_num = $signed(prod_reg);
                div_den = {15'd0, s2};
            end
            ST_X_DIV:
            begin
                div_num = $signed({{36{d_reg[32]}}, d_reg, 30'd0});
                div_den = {15'd0, s2};
            end
            ST_X2_MUL:
            begin
                mul_a = $signed({{33{x_reg[31]}}, x_reg});
                mul_b = $signed({{2{x_reg[31]}}, x_reg});
            end
            ST_P_MUL:
            begin
                mul_a = $signed({34'd0, x2_reg});
                mul_b = $signed({3'd0, t_reg});
            end
            ST_P_DIV:
            begin
                div_num = $signed({30'd0, prod_reg[MP_W-1:30]});
                div_den = {26'd0, poly_div(k_reg)};
            end
            ST_SC_COR:
                cor_ang = half_reg[63:32];
            ST_SC_MUL:
            begin
                mul_a = $signed({{(MA_W-CW){s_reg[CW-1]}}, s_reg});
                mul_b = $signed({16'd0, s2});
            end
            ST_SC_DIV:
            begin
                div_num = d_reg[32] ? -$signed(prod_reg) : $signed(prod_reg);
                div_den = d_abs;
            end
            ST_N_MUL_R:
            begin
                mul_a = $signed({{33{dr_reg[31]}}, dr_reg});
                mul_b = $signed({18'd0, lo_reg});
            end
            ST_N_MUL_L:
            begin
                mul_a = $signed({{33{dl_reg[31]}}, dl_reg});
                mul_b = $signed({18'd0, ro_reg});
            end
            ST_N_DIV:
            begin
                div_num = $signed({{49{n_sum[49]}}, n_sum});
                div_den = {16'd0, sum_reg};
            end
            ST_S_MUL_Q:
            begin
                mul_a = $signed({{32{nq_reg[32]}}, nq_reg});
                mul_b = $signed({{2{sinc_reg[31]}}, sinc_reg});
            end
            ST_S_MUL_R:
            begin
                mul_a = $signed({48'd0, nr_reg});
                mul_b = $signed({{2{sinc_reg[31]}}, sinc_reg});
            end
            ST_S_DIV:
            begin
                div_num = $signed(prod_reg);
                div_den = {16'd0, sum_reg};
            end
            ST_ROT:
                cor_ang = th_reg + half_reg[63:32];
            ST_X_MUL:
            begin
                mul_a = $signed({{31{step_reg[33]}}, step_reg});
                mul_b = c_reg;
            end
            ST_Y_MUL:
            begin
                mul_a = $signed({{31{step_reg[33]}}, step_reg});
                mul_b = s_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Control, configuration and tracked pose
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            k_reg      <= '0;
            mv_reg     <= 1'b0;
            lo_reg     <= 16'd2785;
            ro_reg     <= 16'd2785;
            sx_reg     <= '0;
            sy_reg     <= '0;
            sh_reg     <= '0;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            tx_reg     <= '0;
            ty_reg     <= '0;
            th_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                issued_reg <= 1'b0;
            end
            else if (mul_start || div_start || cor_start)
            begin
                issued_reg <= 1'b1;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LEFT_OFFSET:   lo_reg <= cfg_data[15:0];
                    REG_RIGHT_OFFSET:  ro_reg <= cfg_data[15:0];
                    REG_START_X:       sx_reg <= cfg_data;
                    REG_START_Y:       sy_reg <= cfg_data;
                    REG_START_HEADING: sh_reg <= cfg_data;
                    default:           ;
                endcase
            end

            if (accept)
            begin
                prev_l_reg <= s_tdata[31:0];
                prev_r_reg <= s_tdata[63:32];
                if (s_tuser[0])
                begin
                    tx_reg <= sx_reg;
                    ty_reg <= sy_reg;
                    th_reg <= sh_reg;
                end
            end

            if (state_reg == ST_X2_MUL && mul_done)
            begin
                k_reg <= '0;
            end
            if (state_reg == ST_P_DIV && div_done)
            begin
                k_reg <= k_reg + 1'b1;
            end

            if (state_reg == ST_X_MUL && mul_done)
            begin
                tx_reg <= tx_reg + pos_sum[61:30];
            end
            if (state_reg == ST_Y_MUL && mul_done)
            begin
                ty_reg <= ty_reg + pos_sum[61:30];
                th_reg <= th_reg + dth_sum[63:32];
            end

            if (out_load)
            begin
                mv_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                mv_reg <= 1'b0;
            end
        end
    end

    // Working values of the current item
    always_ff @(posedge clk)
    begin
        if (accept && !s_tuser[0])
        begin
            dl_reg <= s_tdata[31:0] - prev_l_reg;
            dr_reg <= s_tdata[63:32] - prev_r_reg;
        end
        if (state_reg == ST_SETUP)
        begin
            d_reg    <= d_w;
            sum_reg  <= sum_w;
            half_reg <= '0;
            step_reg <= {{2{dr_reg[31]}}, dr_reg};
        end
        if (mul_done)
        begin
            prod_reg <= mul_p;
        end
        case (state_reg)
            ST_HALF_DIV:
                if (div_done) half_reg <= div_quo[63:0];
            ST_X_DIV:
                if (div_done) x_reg <= div_quo[31:0];
            ST_X2_MUL:
                if (mul_done)
                begin
                    x2_reg <= mul_p[60:30];
                    t_reg  <= 31'h4000_0000;
                end
            ST_P_DIV:
                if (div_done)
                begin
                    t_reg    <= t_new;
                    sinc_reg <= {1'b0, t_new};
                end
            ST_SC_COR:
                if (cor_done) s_reg <= cor_sin;
            ST_SC_DIV:
                if (div_done) sinc_reg <= div_quo[31:0];
            ST_N_MUL_R:
                if (mul_done) n_reg <= mul_p[49:0];
            ST_N_DIV:
                if (div_done)
                begin
                    nq_reg <= div_quo[32:0];
                    nr_reg <= div_rem[16:0];
                end
            ST_S_MUL_Q:
                if (mul_done) acc_reg <= mul_p[65:0];
            ST_S_DIV:
                if (div_done) step_reg <= step_sum[63:30];
            ST_ROT:
                if (cor_done)
                begin
                    c_reg <= cor_cos;
                    s_reg <= cor_sin;
                end
            default:
                ;
        endcase
        if (out_load)
        begin
            out_reg <= {th_reg, ty_reg, tx_reg};
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = out_reg;

endmodule

[design/odo_chk.sv]
// Port-level checker for the odometry block, bound to the top level.
module odo_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // A restart with the output free goes straight to the done state and then shows its result
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] && !m_tvalid |=> ##1 m_tvalid)
        else $error("restart result late");

endmodule

bind differential_drive_odometry_top odo_chk u_odo_chk (.*);
